>>> rtl/utl_pkg.sv
// ----------------------------------------------------------------------------
// Ultrasonic tank level package
// Shared types and constants for the echo averaging and fill level core.
// ----------------------------------------------------------------------------
package utl_pkg;

    // Field widths.
    localparam int ECHO_W     = 15;
    localparam int LEVEL_W    = 10;
    localparam int AVG_W      = 15;
    localparam int USED_W     = 4;
    localparam int HEIGHT_W   = 10;
    localparam int OFFSET_W   = 8;
    localparam int CFG_DATA_W = 10;
    localparam int CFG_IDX_W  = 1;

    // Group state widths.
    localparam int SUM_W = 18;
    localparam int CNT_W = 4;

    // Stream widths, padded to whole bytes.
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 32;

    // Serial datapath sizing.
    localparam int MUL_X_W   = 16;
    localparam int MUL_K_W   = 11;
    localparam int MUL_ACC_W = 26;
    localparam int DIV_Q_W   = 26;
    localparam int DIV_D_W   = 16;
    localparam int STEP_W    = 5;
    localparam int MUL_STEPS = MUL_X_W;
    localparam int DIV_STEPS = DIV_Q_W;

    // Echo time to distance in 1/64 cm: (echo * 1124) >> 10.
    localparam logic [MUL_K_W-1:0] CONV_MUL    = 11'd1124;
    localparam int                 CONV_SHIFT  = 10;
    // Fill level scale, tenths of a percent.
    localparam logic [MUL_K_W-1:0] LEVEL_SCALE = 11'd1000;

    // Accepted distance window, 25 cm to 450 cm in 1/64 cm.
    localparam logic [MUL_X_W-1:0] DIST_MIN_Q6 = 16'd1600;
    localparam logic [MUL_X_W-1:0] DIST_MAX_Q6 = 16'd28800;

    // Register reset values.
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 10'd100;
    localparam logic [OFFSET_W-1:0] OFFSET_RESET = 8'd20;

    // Default group length.
    localparam int READINGS_DEF = 3;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TANK_HEIGHT   = 1'b0,
        CFG_SENSOR_OFFSET = 1'b1
    } t_cfg_idx;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_ECHO,
        ST_ACCUM,
        ST_DIV_AVG,
        ST_LEVEL,
        ST_MUL_LVL,
        ST_DIV_LVL,
        ST_OUT
    } t_state;

endpackage

>>> rtl/ultrasonic_tank_level_core.sv
// Each echo reading runs from the input transfer through the bit-serial
// multiplier that scales the echo time to a distance and a step that checks
// and accumulates it, then the core returns to idle before the next one can
// be taken. The reading that closes a group with valid readings also runs a
// restoring divide for the average and, unless the tank height is zero, the
// multiplier again for the level scaling and a second restoring divide by
// the tank height. Only one reading is in work at a time; a finished result
// waits in the output register while the next readings are taken.
// ----------------------------------------------------------------------------
// Ultrasonic tank level core
// Converts echo times to distances, averages the valid ones over a group of
// readings and reports the average distance and the tank fill level.
// ----------------------------------------------------------------------------
module ultrasonic_tank_level_core #(
    parameter int READINGS = utl_pkg::READINGS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Configuration write port
    input  logic                             i_cfg_we,
    input  logic [utl_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [utl_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // Echo readings: tdata = echo_us[14:0], zero pad [15]
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [utl_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // Results: tdata = level_tenth_pct[9:0], avg_distance_q6[24:10],
    // readings_used[28:25], zero pad [31:29]
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [utl_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    // Results: tuser = all_failed[0]
    output logic                             m_axis_tuser
);
    import utl_pkg::*;

    // State and configuration registers.
    t_state                r_state, n_state;
    logic [HEIGHT_W-1:0]   r_height;
    logic [OFFSET_W-1:0]   r_offset;

    // Group accumulation state.
    logic [SUM_W-1:0]      r_sum;
    logic [CNT_W-1:0]      r_vcnt;
    logic [CNT_W-1:0]      r_idx;

    // Serial multiplier and divider registers.
    logic [MUL_X_W-1:0]    r_mul_x;
    logic [MUL_K_W-1:0]    r_mul_k;
    logic [MUL_ACC_W-1:0]  r_mul_acc;
    logic [DIV_Q_W-1:0]    r_div_q;
    logic [DIV_D_W-1:0]    r_div_d;
    logic [DIV_D_W-1:0]    r_div_rem;
    logic [STEP_W-1:0]     r_step;

    // Result under construction and output register.
    logic [LEVEL_W-1:0]    r_level;
    logic [AVG_W-1:0]      r_avg;
    logic [USED_W-1:0]     r_used;
    logic                  r_fail;
    logic                  r_m_valid;
    logic [LEVEL_W-1:0]    r_m_level;
    logic [AVG_W-1:0]      r_m_avg;
    logic [USED_W-1:0]     r_m_used;
    logic                  r_m_fail;

    // Combinational helpers.
    logic                  w_in_xfer;
    logic                  w_out_load;
    logic                  w_step_last;
    logic [MUL_ACC_W-1:0]  w_mul_acc_nxt;
    logic [DIV_D_W:0]      w_div_trial;
    logic                  w_div_ge;
    logic [DIV_D_W:0]      w_div_diff;
    logic [DIV_Q_W-1:0]    w_div_q_nxt;
    logic [DIV_D_W-1:0]    w_div_rem_nxt;
    logic [MUL_X_W-1:0]    w_dist;
    logic                  w_dist_ok;
    logic [SUM_W-1:0]      w_sum_nxt;
    logic [CNT_W-1:0]      w_vcnt_nxt;
    logic [CNT_W-1:0]      w_idx_nxt;
    logic                  w_group_end;
    logic [DIV_D_W-1:0]    w_full;
    logic [SUM_W-1:0]      w_h_raw;
    logic [DIV_D_W-1:0]    w_h;

    // Multiplier step: MSB-first shift and add of the constant.
    assign w_mul_acc_nxt = {r_mul_acc[MUL_ACC_W-2:0], 1'b0}
                         + (r_mul_x[MUL_X_W-1] ? MUL_ACC_W'(r_mul_k) : '0);

    // Divider step: one restoring subtract per cycle.
    assign w_div_trial   = {r_div_rem, r_div_q[DIV_Q_W-1]};
    assign w_div_diff    = w_div_trial - {1'b0, r_div_d};
    assign w_div_ge      = (w_div_trial >= {1'b0, r_div_d});
    assign w_div_rem_nxt = w_div_ge ? w_div_diff[DIV_D_W-1:0]
                                    : w_div_trial[DIV_D_W-1:0];
    assign w_div_q_nxt   = {r_div_q[DIV_Q_W-2:0], w_div_ge};

    // Distance check and group update. A zero echo always lands below the
    // window, so the window test alone rejects it.
    assign w_dist      = r_mul_acc[MUL_ACC_W-1:CONV_SHIFT];
    assign w_dist_ok   = (w_dist >= DIST_MIN_Q6) && (w_dist <= DIST_MAX_Q6);
    assign w_sum_nxt   = w_dist_ok ? r_sum + SUM_W'(w_dist) : r_sum;
    assign w_vcnt_nxt  = r_vcnt + CNT_W'(w_dist_ok);
    assign w_idx_nxt   = r_idx + 1'b1;
    assign w_group_end = (w_idx_nxt == CNT_W'(READINGS));

    // Water height: full - (avg - offset), clamped to 0..full.
    assign w_full  = {r_height, 6'b0};
    assign w_h_raw = SUM_W'(w_full) + SUM_W'({r_offset, 6'b0})
                   - SUM_W'(r_div_q[AVG_W-1:0]);
    always_comb begin
        if (w_h_raw[SUM_W-1]) begin
            w_h = '0;
        end else if (w_h_raw[SUM_W-2:0] > (SUM_W-1)'(w_full)) begin
            w_h = w_full;
        end else begin
            w_h = w_h_raw[DIV_D_W-1:0];
        end
    end

    // Last step of the multiplier or the divider.
    always_comb begin
        case (r_state)
            ST_MUL_ECHO, ST_MUL_LVL: w_step_last = (r_step == STEP_W'(MUL_STEPS - 1));
            ST_DIV_AVG, ST_DIV_LVL:  w_step_last = (r_step == STEP_W'(DIV_STEPS - 1));
            default:                 w_step_last = 1'b0;
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) n_state = ST_MUL_ECHO;
            end
            ST_MUL_ECHO: begin
                if (w_step_last) n_state = ST_ACCUM;
            end
            ST_ACCUM: begin
                if (!w_group_end) n_state = ST_IDLE;
                else if (w_vcnt_nxt == '0) n_state = ST_OUT;
                else n_state = ST_DIV_AVG;
            end
            ST_DIV_AVG: begin
                if (w_step_last) n_state = ST_LEVEL;
            end
            ST_LEVEL: begin
                if (w_full == '0) n_state = ST_OUT;
                else n_state = ST_MUL_LVL;
            end
            ST_MUL_LVL: begin
                if (w_step_last) n_state = ST_DIV_LVL;
            end
            ST_DIV_LVL: begin
                if (w_step_last) n_state = ST_OUT;
            end
            ST_OUT: begin
                if (w_out_load) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State outputs: input ready and output register load.
    always_comb begin
        s_axis_tready = 1'b0;
        w_out_load    = 1'b0;
        unique case (r_state)
            ST_IDLE: s_axis_tready = 1'b1;
            ST_OUT:  w_out_load    = !r_m_valid || m_axis_tready;
            default: begin
                s_axis_tready = 1'b0;
                w_out_load    = 1'b0;
            end
        endcase
    end

    assign w_in_xfer = s_axis_tvalid && s_axis_tready;

    // Control registers: state, configuration, group counters, step count, output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_height  <= HEIGHT_RESET;
            r_offset  <= OFFSET_RESET;
            r_sum     <= '0;
            r_vcnt    <= '0;
            r_idx     <= '0;
            r_step    <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            // Configuration writes.
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_TANK_HEIGHT:   r_height <= i_cfg_data[HEIGHT_W-1:0];
                    CFG_SENSOR_OFFSET: r_offset <= i_cfg_data[OFFSET_W-1:0];
                    default:           r_height <= r_height;
                endcase
            end

            // Group accumulation, cleared when the group closes.
            if (r_state == ST_ACCUM) begin
                if (w_group_end) begin
                    r_sum  <= '0;
                    r_vcnt <= '0;
                    r_idx  <= '0;
                end else begin
                    r_sum  <= w_sum_nxt;
                    r_vcnt <= w_vcnt_nxt;
                    r_idx  <= w_idx_nxt;
                end
            end

            // Step counter for the serial units.
            if (w_step_last) begin
                r_step <= '0;
            end else if (r_state == ST_MUL_ECHO || r_state == ST_MUL_LVL ||
                         r_state == ST_DIV_AVG  || r_state == ST_DIV_LVL) begin
                r_step <= r_step + 1'b1;
            end

            // Output valid: set on load, cleared once the transfer is taken.
            if (w_out_load) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (w_in_xfer) begin
                    r_mul_x   <= {1'b0, s_axis_tdata[ECHO_W-1:0]};
                    r_mul_k   <= CONV_MUL;
                    r_mul_acc <= '0;
                end
            end
            ST_MUL_ECHO: begin
                r_mul_acc <= w_mul_acc_nxt;
                r_mul_x   <= {r_mul_x[MUL_X_W-2:0], 1'b0};
            end
            ST_ACCUM: begin
                // Prepare the average divide and default the result.
                r_used    <= w_vcnt_nxt;
                r_fail    <= (w_vcnt_nxt == '0);
                r_avg     <= '0;
                r_level   <= '0;
                r_div_q   <= DIV_Q_W'(w_sum_nxt);
                r_div_d   <= DIV_D_W'(w_vcnt_nxt);
                r_div_rem <= '0;
            end
            ST_DIV_AVG, ST_DIV_LVL: begin
                r_div_q   <= w_div_q_nxt;
                r_div_rem <= w_div_rem_nxt;
                if (r_state == ST_DIV_LVL && w_step_last) begin
                    r_level <= w_div_q_nxt[LEVEL_W-1:0];
                end
            end
            ST_LEVEL: begin
                r_avg     <= r_div_q[AVG_W-1:0];
                r_mul_x   <= w_h;
                r_mul_k   <= LEVEL_SCALE;
                r_mul_acc <= '0;
            end
            ST_MUL_LVL: begin
                r_mul_acc <= w_mul_acc_nxt;
                r_mul_x   <= {r_mul_x[MUL_X_W-2:0], 1'b0};
                if (w_step_last) begin
                    r_div_q   <= w_mul_acc_nxt;
                    r_div_d   <= w_full;
                    r_div_rem <= '0;
                end
            end
            ST_OUT: begin
                if (w_out_load) begin
                    r_m_level <= r_level;
                    r_m_avg   <= r_avg;
                    r_m_used  <= r_used;
                    r_m_fail  <= r_fail;
                end
            end
            default: begin
                r_mul_acc <= r_mul_acc;
            end
        endcase
    end

    // Output ports.
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {3'b000, r_m_used, r_m_avg, r_m_level};
    assign m_axis_tuser  = r_m_fail;

    // The reading index never reaches the group length between readings.
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx < CNT_W'(READINGS))
        else $error("reading index reached the group length");

    // Valid readings never outnumber the readings taken.
    a_vcnt_le_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vcnt <= r_idx)
        else $error("valid count exceeds reading index");

    // A failed group reports zero level, distance and count.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m_valid && r_m_fail |->
            r_m_level == '0 && r_m_avg == '0 && r_m_used == '0)
        else $error("failed group carries nonzero fields");

    // The reported level never exceeds full scale.
    a_level_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m_valid |-> r_m_level <= LEVEL_W'(LEVEL_SCALE))
        else $error("level above full scale");

    // A result is loaded only from the output state.
    a_load_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_m_valid) |-> $past(r_state) == ST_OUT)
        else $error("output loaded outside the output state");

endmodule

>>> dv/ultrasonic_tank_level_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Ultrasonic tank level core testbench
// Streams echo readings into the core and checks every group report against
// a local model of the averaging and fill level math, or against a typed-in
// report. A directed table comes first, then random phases under several tank
// height and sensor offset settings, with random gaps or bursts per side.
// ----------------------------------------------------------------------------
module ultrasonic_tank_level_core_tb;

    import utl_pkg::*;

    localparam int GROUP_LEN  = READINGS_DEF;
    localparam int PHASES     = 8;
    localparam int PHASE_LEN  = 180;
    localparam int SETTLE_CYC = 120;

    // One group report, as it leaves the core.
    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [AVG_W-1:0]   avg;
        logic [USED_W-1:0]  used;
        logic               all_failed;
    } t_level_report;

    // One directed reading, with a typed-in report where it is obvious.
    typedef struct packed {
        logic [ECHO_W-1:0] echo;
        logic              fixed;
        t_level_report     report;
    } t_echo_row;

    localparam t_level_report NO_REPORT  = '0;
    localparam t_level_report ALL_FAILED = '{level: '0, avg: '0, used: '0, all_failed: 1'b1};

    localparam int DIR_ROWS = 21;
    localparam t_echo_row DIR_TABLE [DIR_ROWS] = '{
        // No echo at all for a whole group.
        '{15'd0,     1'b0, NO_REPORT},
        '{15'd0,     1'b0, NO_REPORT},
        '{15'd0,     1'b1, ALL_FAILED},
        // Largest echo and both window edges just outside: all rejected.
        '{15'd32767, 1'b0, NO_REPORT},
        '{15'd1457,  1'b0, NO_REPORT},
        '{15'd26239, 1'b1, ALL_FAILED},
        // Exactly 25 cm, three times.
        '{15'd1458,  1'b0, NO_REPORT},
        '{15'd1458,  1'b0, NO_REPORT},
        '{15'd1458,  1'b1, '{level: 10'd950, avg: 15'd1600, used: 4'd3, all_failed: 1'b0}},
        // Exactly 450 cm, so far below the surface that the level clamps to 0.
        '{15'd26238, 1'b0, NO_REPORT},
        '{15'd26238, 1'b0, NO_REPORT},
        '{15'd26238, 1'b1, '{level: 10'd0, avg: 15'd28800, used: 4'd3, all_failed: 1'b0}},
        // Mixed groups, checked against the model.
        '{15'd1458,  1'b0, NO_REPORT},
        '{15'd0,     1'b0, NO_REPORT},
        '{15'd26238, 1'b0, NO_REPORT},
        '{15'd5000,  1'b0, NO_REPORT},
        '{15'd32767, 1'b0, NO_REPORT},
        '{15'd1,     1'b0, NO_REPORT},
        '{15'd21845, 1'b0, NO_REPORT},
        '{15'd10922, 1'b0, NO_REPORT},
        '{15'd16384, 1'b0, NO_REPORT}
    };

    // Fixed register settings for all but the last two random phases; zero height is one of them.
    localparam logic [HEIGHT_W-1:0] PHASE_HEIGHT [PHASES] =
        '{10'd1, 10'd1023, 10'd0, 10'd1023, 10'd1, 10'd200, 10'd0, 10'd0};
    localparam logic [OFFSET_W-1:0] PHASE_OFFSET [PHASES] =
        '{8'd0, 8'd255, 8'd0, 8'd0, 8'd255, 8'd40, 8'd0, 8'd0};

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic                  m_axis_tuser;

    // Model state and register copies.
    logic [SUM_W-1:0]    grp_sum;
    logic [CNT_W-1:0]    grp_valid;
    logic [CNT_W-1:0]    grp_count;
    logic [HEIGHT_W-1:0] tank_height_q;
    logic [OFFSET_W-1:0] sensor_offset_q;

    t_level_report pending_reports [$];
    int            error_count = 0;
    bit            send_burst  = 1'b0;
    bit            recv_burst  = 1'b0;

    ultrasonic_tank_level_core #(
        .READINGS(GROUP_LEN)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // 50 MHz clock.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Fill level in tenths of a percent from an average distance.
    function automatic logic [LEVEL_W-1:0] fill_level(input int unsigned avg);
        int full;
        int h;
        full = int'(tank_height_q) * 64;
        h    = full - (int'(avg) - int'(sensor_offset_q) * 64);
        if (h < 0) h = 0;
        if (h > full) h = full;
        if (full == 0) return '0;
        return LEVEL_W'((h * 1000) / full);
    endfunction

    // Folds one reading into the running group; returns 1 when the group closes.
    function automatic bit predict_reading(input logic [ECHO_W-1:0] echo,
                                           output t_level_report report);
        int unsigned distance;
        int unsigned avg;
        distance = (32'(echo) * 32'(CONV_MUL)) >> CONV_SHIFT;
        report   = '0;
        if (echo != '0 && distance >= DIST_MIN_Q6 && distance <= DIST_MAX_Q6) begin
            grp_sum   = grp_sum + SUM_W'(distance);
            grp_valid = grp_valid + 1'b1;
        end
        grp_count = grp_count + 1'b1;
        if (grp_count < GROUP_LEN) return 1'b0;
        if (grp_valid == '0) begin
            report.all_failed = 1'b1;
        end else begin
            avg           = grp_sum / grp_valid;
            report.level  = fill_level(avg);
            report.avg    = AVG_W'(avg);
            report.used   = grp_valid;
        end
        grp_sum   = '0;
        grp_valid = '0;
        grp_count = '0;
        return 1'b1;
    endfunction

    // Mostly in-window echoes, with no-echo and out-of-window readings mixed in.
    function automatic logic [ECHO_W-1:0] draw_echo();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 5) return '0;
        else if (pick < 15) return ECHO_W'($urandom_range(1, 1457));
        else if (pick < 25) return ECHO_W'($urandom_range(26239, 32767));
        else if (pick < 30) return ECHO_W'($urandom);
        else return ECHO_W'($urandom_range(1458, 26238));
    endfunction

    // Register write; the copy used by the model follows it.
    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        if (idx == CFG_TANK_HEIGHT) tank_height_q = data[HEIGHT_W-1:0];
        else sensor_offset_q = data[OFFSET_W-1:0];
    endtask

    // One echo transfer after a random gap, or none in a burst; the expected report
    // is queued on acceptance, either the typed-in one or the one the model computes.
    task automatic send_echo(input logic [ECHO_W-1:0] echo, input logic fixed,
                             input t_level_report fixed_report);
        int            gap;
        t_level_report report;
        gap = send_burst ? 0 : $urandom_range(0, 6);
        repeat (gap) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, echo};
        do @(posedge i_clk); while (!s_axis_tready);
        if (predict_reading(echo, report))
            pending_reports.push_back(fixed ? fixed_report : report);
    endtask

    // Waits until every report has arrived and the core has gone quiet.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    // Result side: random stalls unless in a receive burst, each transfer checked against the oldest report.
    initial begin
        int            gap;
        t_level_report want;
        m_axis_tready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            gap = recv_burst ? 0 : $urandom_range(0, 6);
            repeat (gap) begin
                m_axis_tready <= 1'b0;
                @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            if (pending_reports.size() == 0) begin
                $error("unexpected report transfer: tdata %h tuser %b",
                       m_axis_tdata, m_axis_tuser);
                error_count++;
            end else begin
                want = pending_reports.pop_front();
                if (m_axis_tdata[9:0] !== want.level) begin
                    $error("level_tenth_pct: expected %0d, actual %0d",
                           want.level, m_axis_tdata[9:0]);
                    error_count++;
                end
                if (m_axis_tdata[24:10] !== want.avg) begin
                    $error("avg_distance_q6: expected %0d, actual %0d",
                           want.avg, m_axis_tdata[24:10]);
                    error_count++;
                end
                if (m_axis_tdata[28:25] !== want.used) begin
                    $error("readings_used: expected %0d, actual %0d",
                           want.used, m_axis_tdata[28:25]);
                    error_count++;
                end
                if (m_axis_tuser !== want.all_failed) begin
                    $error("all_failed: expected %0d, actual %0d",
                           want.all_failed, m_axis_tuser);
                    error_count++;
                end
            end
        end
    end

    // Main sequence: reset, directed table, then random phases.
    initial begin
        logic [CFG_DATA_W-1:0] height_data;
        logic [CFG_DATA_W-1:0] offset_data;
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_idx       <= CFG_TANK_HEIGHT;
        i_cfg_data      <= '0;
        s_axis_tvalid   <= 1'b0;
        s_axis_tdata    <= '0;
        grp_sum         = '0;
        grp_valid       = '0;
        grp_count       = '0;
        tank_height_q   = HEIGHT_RESET;
        sensor_offset_q = OFFSET_RESET;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed readings under the reset register values.
        for (int r = 0; r < DIR_ROWS; r++)
            send_echo(DIR_TABLE[r].echo, DIR_TABLE[r].fixed, DIR_TABLE[r].report);
        drain();

        // Random phases; the last two draw their register values at random.
        for (int p = 0; p < PHASES; p++) begin
            if (p >= PHASES - 2) begin
                height_data = CFG_DATA_W'($urandom_range(0, 1023));
                offset_data = CFG_DATA_W'($urandom_range(0, 1023));
            end else begin
                height_data = PHASE_HEIGHT[p];
                offset_data = {2'($urandom_range(0, 3)), PHASE_OFFSET[p]};
            end
            write_reg(CFG_TANK_HEIGHT, height_data);
            write_reg(CFG_SENSOR_OFFSET, offset_data);
            i_cfg_we   <= 1'b0;
            send_burst = p[0];
            recv_burst = p[1];
            for (int n = 0; n < PHASE_LEN; n++)
                send_echo(draw_echo(), 1'b0, NO_REPORT);
            drain();
        end

        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #20_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
